// File: hdl/efnc_pkg.sv
// ---------------------------------------------------------------------------
// efnc_pkg
// Shared types and constants of the eigenface nearest-centroid block.
// ---------------------------------------------------------------------------
package efnc_pkg;

    localparam int NUM_PIXELS     = 4096;
    localparam int MAX_COMPONENTS = 16;
    localparam int MAX_PERSONS    = 64;

    localparam int PIX_W   = $clog2(NUM_PIXELS);
    localparam int COMP_W  = $clog2(MAX_COMPONENTS);
    localparam int PERS_W  = $clog2(MAX_PERSONS);
    localparam int CENT_AW = PERS_W + COMP_W;
    localparam int NCOMP_W = 5;
    localparam int NPERS_W = 7;
    localparam int VAL_W   = 24;
    localparam int STORE_W = 16;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = 34;
    localparam int CTR_W   = 18;
    localparam int FEAT_W  = 24;
    localparam int DIFF_W  = 25;
    localparam int SQ_W    = 49;
    localparam int DIST_W  = 54;
    localparam int STAT_W  = 2;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [STAT_W-1:0] ST_MATCH    = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTREADY = 2'd2;

    localparam logic [1:0] REG_MODEL_READY = 2'd0;
    localparam logic [1:0] REG_ACTIVE_COMP = 2'd1;
    localparam logic [1:0] REG_PERSON_CNT  = 2'd2;
    localparam logic [1:0] REG_THRESHOLD   = 2'd3;

    typedef enum logic [1:0] {
        REQ_MEAN  = 2'd0,
        REQ_BASIS = 2'd1,
        REQ_CENT  = 2'd2,
        REQ_PIX   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [PIX_W-1:0]         pix;
        logic [COMP_W-1:0]        comp;
        logic [PERS_W-1:0]        person;
        logic signed [VAL_W-1:0]  value;
        logic                     last;
    } t_req;

    typedef struct packed {
        logic                     model_ready;
        logic [NCOMP_W-1:0]       active_components;
        logic [NPERS_W-1:0]       person_count;
        logic [DIST_W-1:0]        threshold;
    } t_cfg;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [PERS_W-1:0]        person_id;
        logic [DIST_W-1:0]        distance_sq;
    } t_res;

endpackage

// File: hdl/efnc_if.sv
// ---------------------------------------------------------------------------
// efnc_in_if / efnc_out_if
// Valid/ready channels for request words and result words.
// ---------------------------------------------------------------------------
interface efnc_in_if;
    import efnc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic [PIX_W-1:0]        pixel_index;
    logic [COMP_W-1:0]       comp_index;
    logic [PERS_W-1:0]       person_index;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    modport source (output valid, req_type, pixel_index, comp_index, person_index,
                    value, last, input ready);
    modport sink   (input valid, req_type, pixel_index, comp_index, person_index,
                    value, last, output ready);
endinterface

interface efnc_out_if;
    import efnc_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [PERS_W-1:0]   person_id;
    logic [DIST_W-1:0]   distance_sq;
    modport source (output valid, status, person_id, distance_sq, input ready);
    modport sink   (input valid, status, person_id, distance_sq, output ready);
endinterface

// File: hdl/efnc_ram.sv
// ---------------------------------------------------------------------------
// efnc_ram
// Single-port RAM with registered read.
// ---------------------------------------------------------------------------
module efnc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/efnc_front.sv
// ---------------------------------------------------------------------------
// efnc_front
// Accepts request words, tags their kind and queues them for the back end.
// ---------------------------------------------------------------------------
module efnc_front
    import efnc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    efnc_in_if.sink   i_req,
    output logic      o_q_valid,
    output t_req      o_q_data,
    input  logic      i_q_pop
);
    t_req              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              push;
    logic              pop;
    t_req              w_item;

    assign i_req.ready = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_q_pop && o_q_valid;
    assign o_q_valid   = (r_cnt != '0);
    assign o_q_data    = r_q[r_rd];

    always_comb begin
        w_item.kind   = t_kind'(i_req.req_type);
        w_item.pix    = i_req.pixel_index;
        w_item.comp   = i_req.comp_index;
        w_item.person = i_req.person_index;
        w_item.value  = i_req.value;
        w_item.last   = i_req.last;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: hdl/efnc_back.sv
// ---------------------------------------------------------------------------
// efnc_back
// Executes queued words: table loads, per-pixel projection MACs, and the
// nearest-centroid search on the last pixel (if model_ready and person_count is nonzero).
// ---------------------------------------------------------------------------
module efnc_back
    import efnc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_req      i_q_data,
    output logic      o_q_pop,
    efnc_out_if.source o_res
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EXEC = 9'b000000010,
        S_QMUL = 9'b000000100,
        S_QACC = 9'b000001000,
        S_FEAT = 9'b000010000,
        S_RD   = 9'b000100000,
        S_SQ   = 9'b001000000,
        S_ADD  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_req   r_item;

    logic [STORE_W-1:0]        mean_rd;
    logic [STORE_W-1:0]        basis_rd [MAX_COMPONENTS];
    logic [VAL_W-1:0]          cent_rd;
    logic [CENT_AW-1:0]        cent_addr;
    logic                      cent_we;

    logic signed [PROD_W-1:0]  r_prod [MAX_COMPONENTS];
    logic [ACC_W-1:0]          r_acc  [MAX_COMPONENTS];
    logic signed [FEAT_W-1:0]  r_feat [MAX_COMPONENTS];

    logic [PERS_W-1:0]         r_p;
    logic [COMP_W-1:0]         r_c;
    logic [SQ_W-1:0]           r_sq;
    logic [DIST_W-1:0]         r_d;
    logic [DIST_W-1:0]         r_best;
    logic [PERS_W-1:0]         r_bestp;
    t_res                      r_res;
    logic                      r_out_valid;
    t_res                      r_out;

    logic [NCOMP_W-1:0]        ncomp;
    logic [NPERS_W-1:0]        npers;
    logic signed [CTR_W-1:0]   centered;
    logic [8:0]                px;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         adiff;
    logic [2*DIFF_W-1:0]       sq_full;
    logic [DIST_W:0]           dsum_w;
    logic [DIST_W-1:0]         dsum;
    logic                      last_c;
    logic                      last_p;

    always_comb begin
        if (i_cfg.active_components == '0) begin
            ncomp = NCOMP_W'(1);
        end else if (i_cfg.active_components > NCOMP_W'(MAX_COMPONENTS)) begin
            ncomp = NCOMP_W'(MAX_COMPONENTS);
        end else begin
            ncomp = i_cfg.active_components;
        end
        if (i_cfg.person_count > NPERS_W'(MAX_PERSONS)) begin
            npers = NPERS_W'(MAX_PERSONS);
        end else begin
            npers = i_cfg.person_count;
        end
    end

    // memories
    assign cent_we   = (r_state == S_EXEC) && (r_item.kind == REQ_CENT);
    assign cent_addr = cent_we ? {r_item.person, r_item.comp} : {r_p, r_c};

    efnc_ram #(.WIDTH(STORE_W), .DEPTH(NUM_PIXELS)) u_mean (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_EXEC) && (r_item.kind == REQ_MEAN)),
        .i_addr  (r_item.pix),
        .i_wdata (r_item.value[STORE_W-1:0]),
        .o_rdata (mean_rd)
    );

    for (genvar g = 0; g < MAX_COMPONENTS; g++) begin : g_basis
        efnc_ram #(.WIDTH(STORE_W), .DEPTH(NUM_PIXELS)) u_basis (
            .i_clk   (i_clk),
            .i_we    ((r_state == S_EXEC) && (r_item.kind == REQ_BASIS)
                      && (r_item.comp == COMP_W'(g))),
            .i_addr  (r_item.pix),
            .i_wdata (r_item.value[STORE_W-1:0]),
            .o_rdata (basis_rd[g])
        );
    end

    efnc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PERSONS*MAX_COMPONENTS)) u_cent (
        .i_clk   (i_clk),
        .i_we    (cent_we),
        .i_addr  (cent_addr),
        .i_wdata (r_item.value),
        .o_rdata (cent_rd)
    );

    // datapath
    always_comb begin
        if (r_item.value < 0) begin
            px = '0;
        end else if (r_item.value > VAL_W'(255)) begin
            px = 9'd255;
        end else begin
            px = r_item.value[8:0];
        end
        centered = $signed({2'b00, px, 7'b0}) - CTR_W'($signed(mean_rd));
        diff     = DIFF_W'(r_feat[r_c]) - DIFF_W'($signed(cent_rd));
        adiff    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        sq_full  = adiff * adiff;
        dsum_w   = {1'b0, r_d} + (DIST_W+1)'(r_sq);
        dsum     = (dsum_w > {1'b0, DIST_MAX}) ? DIST_MAX : dsum_w[DIST_W-1:0];
        last_c   = ({1'b0, r_c} == NCOMP_W'(ncomp - 1'b1));
        last_p   = ({1'b0, r_p} == NPERS_W'(npers - 1'b1));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_QMUL) begin
            for (int k = 0; k < MAX_COMPONENTS; k++) begin
                r_prod[k] <= centered * $signed(basis_rd[k]);
            end
        end
        if (r_state == S_FEAT) begin
            for (int k = 0; k < MAX_COMPONENTS; k++) begin
                logic signed [ACC_W:0]       t;
                logic signed [ACC_W-22:0]    q;
                t = $signed({r_acc[k][ACC_W-1], r_acc[k]}) + (ACC_W+1)'(1 << 21);
                q = (ACC_W-21)'(t >>> 22);
                if (q > (ACC_W-21)'(8388607)) begin
                    r_feat[k] <= FEAT_W'(8388607);
                end else if (q < -(ACC_W-21)'(8388608)) begin
                    r_feat[k] <= -FEAT_W'(8388608);
                end else begin
                    r_feat[k] <= q[FEAT_W-1:0];
                end
            end
        end
        if (r_state == S_SQ) begin
            r_sq <= sq_full[SQ_W-1:0];
        end
        if (r_state == S_IDLE) begin
            r_item <= i_q_data;
        end
    end

    assign o_q_pop = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_EXEC;
            S_EXEC: n_state = (r_item.kind == REQ_PIX) ? S_QMUL : S_IDLE;
            S_QMUL: n_state = S_QACC;
            S_QACC: n_state = r_item.last ? S_FEAT : S_IDLE;
            S_FEAT: n_state = (!i_cfg.model_ready || npers == '0) ? S_OUT : S_RD;
            S_RD:   n_state = S_SQ;
            S_SQ:   n_state = S_ADD;
            S_ADD:  n_state = (last_c && last_p) ? S_OUT : S_RD;
            S_OUT:  if (!r_out_valid || o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_p         <= '0;
            r_c         <= '0;
            r_d         <= '0;
            r_best      <= DIST_MAX;
            r_bestp     <= '0;
            for (int k = 0; k < MAX_COMPONENTS; k++) begin
                r_acc[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_QACC: begin
                    for (int k = 0; k < MAX_COMPONENTS; k++) begin
                        r_acc[k] <= r_acc[k] + ACC_W'(r_prod[k]);
                    end
                end
                S_FEAT: begin
                    for (int k = 0; k < MAX_COMPONENTS; k++) begin
                        r_acc[k] <= '0;
                    end
                    r_p     <= '0;
                    r_c     <= '0;
                    r_d     <= '0;
                    r_best  <= DIST_MAX;
                    r_bestp <= '0;
                    r_res.status      <= ST_NOTREADY;
                    r_res.person_id   <= '0;
                    r_res.distance_sq <= DIST_MAX;
                end
                S_ADD: begin
                    if (last_c) begin
                        r_c <= '0;
                        r_d <= '0;
                        if (dsum < r_best) begin
                            r_best  <= dsum;
                            r_bestp <= r_p;
                        end
                        if (last_p) begin
                            r_res.person_id   <= (dsum < r_best) ? r_p : r_bestp;
                            r_res.distance_sq <= (dsum < r_best) ? dsum : r_best;
                            r_res.status <= (((dsum < r_best) ? dsum : r_best)
                                             > i_cfg.threshold) ? ST_UNKNOWN : ST_MATCH;
                        end else begin
                            r_p <= r_p + 1'b1;
                        end
                    end else begin
                        r_c <= r_c + 1'b1;
                        r_d <= dsum;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_valid || o_res.ready)) begin
            r_out <= r_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.person_id   = r_out.person_id;
    assign o_res.distance_sq = r_out.distance_sq;
endmodule

// File: hdl/eigenface_nearest_centroid.sv
// ---------------------------------------------------------------------------
// eigenface_nearest_centroid
// Eigenface projection with nearest-centroid search and APB register port.
// ---------------------------------------------------------------------------
// Load words (mean, basis, centroid) are written in the back end's execute
// state, a query pixel passes RAM read, 16 parallel MACs and accumulate. On
// the last pixel the search reads one centroid entry per step (read, square,
// add) over every active component of every person, then outputs the result.
// A 4-word queue buffers input words meanwhile. Stores have no reset; a query
// touching unloaded entries gives undefined results. Registers sit at 8*i.
module eigenface_nearest_centroid
    import efnc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    efnc_in_if.sink     i_req,
    efnc_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    t_cfg r_cfg;
    logic q_valid;
    t_req q_data;
    logic q_pop;
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.model_ready       <= 1'b0;
            r_cfg.active_components <= NCOMP_W'(1);
            r_cfg.person_count      <= '0;
            r_cfg.threshold         <= DIST_MAX;
        end else if (cfg_we) begin
            unique case (paddr[4:3])
                REG_MODEL_READY: r_cfg.model_ready       <= pwdata[0];
                REG_ACTIVE_COMP: r_cfg.active_components <= pwdata[NCOMP_W-1:0];
                REG_PERSON_CNT:  r_cfg.person_count      <= pwdata[NPERS_W-1:0];
                REG_THRESHOLD:   r_cfg.threshold         <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_MODEL_READY: prdata = 64'(r_cfg.model_ready);
            REG_ACTIVE_COMP: prdata = 64'(r_cfg.active_components);
            REG_PERSON_CNT:  prdata = 64'(r_cfg.person_count);
            REG_THRESHOLD:   prdata = 64'(r_cfg.threshold);
            default:         prdata = '0;
        endcase
    end

    efnc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_pop   (q_pop)
    );

    efnc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );
endmodule
